/* src/sti_pkg.sv */
// Shared operation codes, status codes and the result record of the sorted table.
package sti_pkg;

   localparam logic [2:0] KIND_INSERT     = 3'd0;
   localparam logic [2:0] KIND_REMOVE_ONE = 3'd1;
   localparam logic [2:0] KIND_REMOVE_ALL = 3'd2;
   localparam logic [2:0] KIND_READ_AT    = 3'd3;
   localparam logic [2:0] KIND_CLEAR      = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_RANGE     = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [6:0]         entry_count;
      logic [6:0]         removed_count;
      status_type         status;
   } result_type;

endpackage

/* src/sti_ram.sv */
// Single-port-write, single-port-read entry memory with registered read data.
module sti_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic signed [31:0]   wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic signed [31:0]   rd_data
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sti_engine.sv */
// Sequencer that walks the entry memory to insert, remove and read entries.
module sti_engine import sti_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int AW       = 6,
   parameter int CW       = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_kind,
   input  logic signed [31:0]   req_item_value,
   input  logic [5:0]           req_position,
   output logic                 req_ready,
   output logic [AW-1:0]        mem_raddr,
   input  logic signed [31:0]   mem_rdata,
   output logic                 mem_we,
   output logic [AW-1:0]        mem_waddr,
   output logic signed [31:0]   mem_wdata,
   output logic                 res_valid,
   output result_type           res,
   input  logic                 res_take
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type          state_ff, state_in;
   logic [2:0]         kind_ff, kind_in;
   logic signed [31:0] val_ff, val_in;
   logic signed [31:0] carry_ff, carry_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      gone_ff, gone_in;
   result_type         res_ff, res_in;

   logic at_end;

   assign at_end = (idx_ff == count_ff);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      val_in    = val_ff;
      carry_in  = carry_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      gone_in   = gone_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(idx_ff);
      mem_wdata = carry_ff;
      mem_raddr = AW'(idx_ff + CW'(1));
      case (state_ff)
         ST_IDLE: begin
            mem_raddr = (req_kind == KIND_READ_AT) ? AW'(req_position) : '0;
            if (req_valid) begin
               kind_in  = req_kind;
               val_in   = req_item_value;
               carry_in = req_item_value;
               idx_in   = '0;
               gone_in  = '0;
               res_in   = '{read_value: '0, entry_count: 7'(count_ff),
                            removed_count: '0, status: STATUS_OK};
               state_in = ST_SCAN;
               case (req_kind)
                  KIND_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        res_in.status = STATUS_FULL;
                        state_in      = ST_DONE;
                     end
                  end
                  KIND_REMOVE_ONE, KIND_REMOVE_ALL: ;
                  KIND_READ_AT: begin
                     if (32'(req_position) >= 32'(count_ff)) begin
                        res_in.status = STATUS_RANGE;
                        state_in      = ST_DONE;
                     end
                  end
                  KIND_CLEAR: begin
                     res_in.removed_count = 7'(count_ff);
                     res_in.entry_count   = '0;
                     count_in             = '0;
                     state_in             = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + CW'(1);
            case (kind_ff)
               KIND_INSERT: begin
                  if (at_end) begin
                     mem_we             = 1'b1;
                     count_in           = count_ff + CW'(1);
                     res_in.entry_count = 7'(count_ff + CW'(1));
                     state_in           = ST_DONE;
                  end else if (!(mem_rdata < val_ff)) begin
                     // Ripple: drop the carried value here and carry the old entry on.
                     mem_we   = 1'b1;
                     carry_in = mem_rdata;
                  end
               end
               KIND_REMOVE_ONE, KIND_REMOVE_ALL: begin
                  if (at_end) begin
                     count_in             = count_ff - gone_ff;
                     res_in.entry_count   = 7'(count_ff - gone_ff);
                     res_in.removed_count = 7'(gone_ff);
                     res_in.status = (gone_ff == '0) ? STATUS_NOT_FOUND : STATUS_OK;
                     state_in             = ST_DONE;
                  end else if (mem_rdata == val_ff &&
                               (kind_ff == KIND_REMOVE_ALL || gone_ff == '0)) begin
                     gone_in = gone_ff + CW'(1);
                  end else if (gone_ff != '0) begin
                     // Compact the tail down over the removed entries.
                     mem_we    = 1'b1;
                     mem_waddr = AW'(idx_ff - gone_ff);
                     mem_wdata = mem_rdata;
                  end
               end
               default: begin
                  res_in.read_value = mem_rdata;
                  state_in          = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      kind_ff  <= kind_in;
      val_ff   <= val_in;
      carry_ff <= carry_in;
      idx_ff   <= idx_in;
      gone_ff  <= gone_in;
      res_ff   <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

/* src/sorted_table_insert_remove.sv */
// Sorted table of signed 32-bit entries with insert, remove, remove-all, read-at and clear.
// Each request beat runs one operation on an ascending table held in a single synchronous
// memory. Insert, remove and remove-all stream the stored entries through the memory's one
// read and one write port, one entry per cycle; read-at reads the single entry at its
// position, while clear, an insert into a full table, a read-at out of range and an unused
// operation code go straight to the response. One request is worked on at a time; a
// finished response sits in an output register so the next request can be taken while the
// response waits. Every response carries the entry count after the operation. After reset
// the table is empty and needs no clearing pass.
module sorted_table_insert_remove import sti_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_kind,
   input  logic signed [31:0]   req_item_value,
   input  logic [5:0]           req_position,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_read_value,
   output logic [6:0]           rsp_entry_count,
   output logic [6:0]           rsp_removed_count,
   output logic [1:0]           rsp_status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   logic signed [31:0] mem_wdata;
   logic signed [31:0] mem_rdata;
   logic               res_valid;
   logic               res_take;
   result_type         res;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   sti_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sti_engine #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_kind       (req_kind),
      .req_item_value (req_item_value),
      .req_position   (req_position),
      .req_ready      (req_ready),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .res_valid      (res_valid),
      .res            (res),
      .res_take       (res_take)
   );

   // The output register takes a finished result whenever it is empty or being drained.
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_ff.read_value;
   assign rsp_entry_count   = rsp_ff.entry_count;
   assign rsp_removed_count = rsp_ff.removed_count;
   assign rsp_status        = rsp_ff.status;

   // One request at a time: after a request beat the next one is not taken at once.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous one was in progress");

   // The count never grows past the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_entry_count) <= CAPACITY))
      else $error("entry count exceeds capacity");

   // A failed search or a full table deletes nothing and reads nothing.
   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NOT_FOUND || rsp_status == STATUS_FULL))
      |-> (rsp_removed_count == '0 && rsp_read_value == '0))
      else $error("failed operation reported removed entries or data");

endmodule
